// ===== rtl/prefix_key_block_entry_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// prefix_key_block_entry_decoder assertion macros
// Shared property forms used by the entry decoder RTL.
// ----------------------------------------------------------------------------
`ifndef PREFIX_KEY_BLOCK_ENTRY_DECODER_ASSERT_SVH
`define PREFIX_KEY_BLOCK_ENTRY_DECODER_ASSERT_SVH

// same-cycle implication
`define PKBED_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pkbed assertion failed");

// next-cycle implication
`define PKBED_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pkbed assertion failed");

`endif

// ===== rtl/pkbed_pkg.sv =====
// ----------------------------------------------------------------------------
// pkbed_pkg
// Types and constants of the prefix-compressed block entry decoder.
// ----------------------------------------------------------------------------
package pkbed_pkg;

    localparam int KeyBytesMax = 64;
    localparam int KeyAddrW    = $clog2(KeyBytesMax);
    localparam int KeyLenW     = $clog2(KeyBytesMax + 1);
    localparam int KeyLenPad   = 16 - KeyLenW;

    localparam logic [15:0] MinHeader  = 16'd3;
    localparam logic [15:0] LenSat     = 16'hFFFF;
    localparam int          ContBit    = 7;
    localparam logic [2:0]  VarintLast = 3'd4;

    typedef enum logic [2:0] {
        PH_SHARED,
        PH_UNSHARED,
        PH_VALUE,
        PH_KEY,
        PH_VAL
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_KEY    = 2'd1,
        KIND_VALUE  = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_VARINT   = 3'd1,
        ERR_PREFIX   = 3'd2,
        ERR_REGION   = 3'd3,
        ERR_KEY_LONG = 3'd4
    } err_code_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [15:0] position;
        logic [15:0] shared_len;
        logic [15:0] unshared_len;
        logic [15:0] value_len;
        logic        end_of_entry;
        logic        block_done;
        err_code_t   error_code;
        logic        last_of_run;
    } result_t;

endpackage

// ===== rtl/pkbed_ram.sv =====
// ----------------------------------------------------------------------------
// pkbed_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pkbed_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/prefix_key_block_entry_decoder.sv =====
// ----------------------------------------------------------------------------
// prefix_key_block_entry_decoder
// Decodes prefix-compressed key/value entries of a sorted-table block.
// ----------------------------------------------------------------------------
// Takes one region byte per transfer. Header and key/value bytes are taken in
// ST_IDLE; completing a header adds ST_CHECK for the length checks, and each
// reused prefix byte then passes through ST_READ and ST_EMIT, set by the key
// store RAM (registered read in ST_READ, output register load in ST_EMIT).
// A zero-prefix header gives a single header result. Output is held in a
// one-deep register; a new byte is taken only while that register is empty
// or its result transfers in the same cycle.
// After a corruption result nothing is produced until a block_start transfer.
// ----------------------------------------------------------------------------
`include "prefix_key_block_entry_decoder_assert.svh"

module prefix_key_block_entry_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,       // region_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] block_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // out_byte, position, shared_len,
                                        // unshared_len, value_len, end_of_entry,
                                        // block_done, error_code, zero pad
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last_of_run
);

    pkbed_pkg::state_t  state_reg, state_next;
    pkbed_pkg::phase_t  phase_reg, phase_next;
    logic [15:0]        rl_reg;
    logic [15:0]        bc_reg, bc_next;
    logic [15:0]        acc_reg, acc_next;
    logic               ovf_reg, ovf_next;
    logic [2:0]         vb_reg, vb_next;
    logic [15:0]        fl0_reg, fl0_next;
    logic [15:0]        fl1_reg, fl1_next;
    logic [15:0]        fl2_reg, fl2_next;
    logic [15:0]        rem_reg, rem_next;
    logic [pkbed_pkg::KeyLenW-1:0] key_len_reg, key_len_next;
    logic [pkbed_pkg::KeyLenW-1:0] rd_idx_reg, rd_idx_next;
    logic               err_reg, err_next;
    logic               m_valid_reg, m_valid_next;
    pkbed_pkg::result_t out_reg, out_next;

    logic               in_fire;
    logic               out_free;
    logic               hdr_done;
    logic               ram_we;
    logic               ram_re;
    logic [7:0]         ram_rdata;

    // header checks
    logic [15:0]        chk_left;
    logic [16:0]        chk_need;
    logic [16:0]        chk_key;
    pkbed_pkg::err_code_t chk_code;
    logic               chk_empty;
    logic               chk_done;
    logic               replay_last;

    assign cfg_ready     = 1'b1;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == pkbed_pkg::ST_IDLE) && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last_of_run;
    assign m_axis_tdata  = {3'b000, out_reg.error_code, out_reg.block_done,
                            out_reg.end_of_entry, out_reg.value_len,
                            out_reg.unshared_len, out_reg.shared_len,
                            out_reg.position, out_reg.out_byte};

    assign chk_left  = (bc_reg < rl_reg) ? (rl_reg - bc_reg) : 16'd0;
    assign chk_need  = {1'b0, fl1_reg} + {1'b0, fl2_reg};
    assign chk_key   = {1'b0, fl0_reg} + {1'b0, fl1_reg};
    assign chk_empty = (fl1_reg == 16'd0) && (fl2_reg == 16'd0);
    assign chk_done  = bc_reg >= rl_reg;
    assign replay_last = ({{pkbed_pkg::KeyLenPad{1'b0}}, rd_idx_reg} + 16'd1) == fl0_reg;

    always_comb
    begin
        if (chk_need > {1'b0, chk_left})
        begin
            chk_code = pkbed_pkg::ERR_REGION;
        end
        else if (fl0_reg > {{pkbed_pkg::KeyLenPad{1'b0}}, key_len_reg})
        begin
            chk_code = pkbed_pkg::ERR_PREFIX;
        end
        else if (chk_key > 17'(pkbed_pkg::KeyBytesMax))
        begin
            chk_code = pkbed_pkg::ERR_KEY_LONG;
        end
        else
        begin
            chk_code = pkbed_pkg::ERR_NONE;
        end
    end

    pkbed_ram #(
        .Width (8),
        .Depth (pkbed_pkg::KeyBytesMax)
    ) u_key_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (key_len_reg[pkbed_pkg::KeyAddrW-1:0]),
        .wr_data (s_axis_tdata),
        .rd_en   (ram_re),
        .rd_addr (rd_idx_reg[pkbed_pkg::KeyAddrW-1:0]),
        .rd_data (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pkbed_pkg::ST_IDLE:
            begin
                if (in_fire && hdr_done)
                begin
                    state_next = pkbed_pkg::ST_CHECK;
                end
            end
            pkbed_pkg::ST_CHECK:
            begin
                if (out_free)
                begin
                    if (chk_code == pkbed_pkg::ERR_NONE && fl0_reg != 16'd0)
                    begin
                        state_next = pkbed_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = pkbed_pkg::ST_IDLE;
                    end
                end
            end
            pkbed_pkg::ST_READ:
            begin
                state_next = pkbed_pkg::ST_EMIT;
            end
            pkbed_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = replay_last ? pkbed_pkg::ST_IDLE : pkbed_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = pkbed_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pkbed_pkg::phase_t    cur_phase;
        logic [15:0]          cur_bc;
        logic [15:0]          cur_acc;
        logic                 cur_ovf;
        logic [2:0]           cur_vb;
        logic                 cur_err;
        logic                 entry_start;
        logic [15:0]          acc_add;
        logic                 ovf_add;
        logic [15:0]          acc_sum;
        logic                 ovf_sum;
        logic [15:0]          field_val;
        logic [15:0]          rem_dec;
        logic                 do_fail;
        pkbed_pkg::err_code_t fail_code;
        logic                 do_emit;
        logic                 finish;

        phase_next   = phase_reg;
        bc_next      = bc_reg;
        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        vb_next      = vb_reg;
        fl0_next     = fl0_reg;
        fl1_next     = fl1_reg;
        fl2_next     = fl2_reg;
        rem_next     = rem_reg;
        key_len_next = key_len_reg;
        rd_idx_next  = rd_idx_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        out_next     = out_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        hdr_done     = 1'b0;

        cur_phase   = s_axis_tuser ? pkbed_pkg::PH_SHARED : phase_reg;
        cur_bc      = s_axis_tuser ? 16'd0 : bc_reg;
        cur_acc     = s_axis_tuser ? 16'd0 : acc_reg;
        cur_ovf     = s_axis_tuser ? 1'b0 : ovf_reg;
        cur_vb      = s_axis_tuser ? 3'd0 : vb_reg;
        cur_err     = s_axis_tuser ? 1'b0 : err_reg;
        entry_start = (cur_phase == pkbed_pkg::PH_SHARED) && (cur_vb == 3'd0);
        acc_add     = 16'd0;
        ovf_add     = 1'b0;
        acc_sum     = 16'd0;
        ovf_sum     = 1'b0;
        field_val   = 16'd0;
        rem_dec     = rem_reg - {15'd0, rem_reg != 16'd0};
        do_fail     = 1'b0;
        fail_code   = pkbed_pkg::ERR_NONE;
        do_emit     = 1'b0;
        finish      = 1'b0;

        unique case (state_reg)
            pkbed_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser)
                    begin
                        phase_next   = pkbed_pkg::PH_SHARED;
                        bc_next      = 16'd0;
                        acc_next     = 16'd0;
                        ovf_next     = 1'b0;
                        vb_next      = 3'd0;
                        fl0_next     = 16'd0;
                        fl1_next     = 16'd0;
                        fl2_next     = 16'd0;
                        rem_next     = 16'd0;
                        key_len_next = '0;
                        err_next     = 1'b0;
                    end
                    if (!cur_err)
                    begin
                        unique case (cur_phase) inside
                            pkbed_pkg::PH_SHARED,
                            pkbed_pkg::PH_UNSHARED,
                            pkbed_pkg::PH_VALUE:
                            begin
                                if (entry_start && cur_bc >= rl_reg)
                                begin
                                    // region used up: byte dropped
                                end
                                else if (entry_start && (rl_reg - cur_bc) < pkbed_pkg::MinHeader)
                                begin
                                    do_fail   = 1'b1;
                                    fail_code = pkbed_pkg::ERR_REGION;
                                end
                                else if (!entry_start && cur_bc >= rl_reg)
                                begin
                                    do_fail   = 1'b1;
                                    fail_code = pkbed_pkg::ERR_REGION;
                                end
                                else
                                begin
                                    bc_next = cur_bc + 16'd1;
                                    case (cur_vb)
                                        3'd0: acc_add = {9'd0, s_axis_tdata[6:0]};
                                        3'd1: acc_add = {2'd0, s_axis_tdata[6:0], 7'd0};
                                        3'd2:
                                        begin
                                            acc_add = {s_axis_tdata[1:0], 14'd0};
                                            ovf_add = |s_axis_tdata[6:2];
                                        end
                                        3'd3: ovf_add = |s_axis_tdata[6:0];
                                        default: ovf_add = |s_axis_tdata[3:0];
                                    endcase
                                    acc_sum = cur_acc | acc_add;
                                    ovf_sum = cur_ovf | ovf_add;
                                    if (s_axis_tdata[pkbed_pkg::ContBit])
                                    begin
                                        if (cur_vb >= pkbed_pkg::VarintLast)
                                        begin
                                            do_fail   = 1'b1;
                                            fail_code = pkbed_pkg::ERR_VARINT;
                                        end
                                        else
                                        begin
                                            vb_next  = cur_vb + 3'd1;
                                            acc_next = acc_sum;
                                            ovf_next = ovf_sum;
                                        end
                                    end
                                    else
                                    begin
                                        field_val = ovf_sum ? pkbed_pkg::LenSat : acc_sum;
                                        acc_next  = 16'd0;
                                        ovf_next  = 1'b0;
                                        vb_next   = 3'd0;
                                        case (cur_phase)
                                            pkbed_pkg::PH_SHARED:
                                            begin
                                                fl0_next   = field_val;
                                                phase_next = pkbed_pkg::PH_UNSHARED;
                                            end
                                            pkbed_pkg::PH_UNSHARED:
                                            begin
                                                fl1_next   = field_val;
                                                phase_next = pkbed_pkg::PH_VALUE;
                                            end
                                            default:
                                            begin
                                                fl2_next = field_val;
                                                hdr_done = 1'b1;
                                            end
                                        endcase
                                    end
                                end
                            end
                            pkbed_pkg::PH_KEY:
                            begin
                                if (bc_reg != 16'hFFFF)
                                begin
                                    bc_next = bc_reg + 16'd1;
                                end
                                do_emit           = 1'b1;
                                out_next.kind     = pkbed_pkg::KIND_KEY;
                                out_next.out_byte = s_axis_tdata;
                                out_next.position = {{pkbed_pkg::KeyLenPad{1'b0}}, key_len_reg};
                                if (key_len_reg < pkbed_pkg::KeyLenW'(pkbed_pkg::KeyBytesMax))
                                begin
                                    ram_we       = 1'b1;
                                    key_len_next = key_len_reg + pkbed_pkg::KeyLenW'(1);
                                end
                                rem_next = rem_dec;
                                if (rem_dec == 16'd0)
                                begin
                                    if (fl2_reg != 16'd0)
                                    begin
                                        phase_next = pkbed_pkg::PH_VAL;
                                        rem_next   = fl2_reg;
                                    end
                                    else
                                    begin
                                        finish = 1'b1;
                                    end
                                end
                            end
                            default:
                            begin
                                if (bc_reg != 16'hFFFF)
                                begin
                                    bc_next = bc_reg + 16'd1;
                                end
                                do_emit           = 1'b1;
                                out_next.kind     = pkbed_pkg::KIND_VALUE;
                                out_next.out_byte = s_axis_tdata;
                                out_next.position = fl2_reg - rem_reg;
                                rem_next          = rem_dec;
                                finish            = (rem_dec == 16'd0);
                            end
                        endcase
                        if (finish)
                        begin
                            phase_next = pkbed_pkg::PH_SHARED;
                        end
                        out_next.end_of_entry = finish;
                        out_next.block_done   = finish && (bc_next >= rl_reg);
                    end
                end
            end
            pkbed_pkg::ST_CHECK:
            begin
                if (out_free)
                begin
                    if (chk_code != pkbed_pkg::ERR_NONE)
                    begin
                        do_fail   = 1'b1;
                        fail_code = chk_code;
                    end
                    else
                    begin
                        key_len_next = fl0_reg[pkbed_pkg::KeyLenW-1:0];
                        rd_idx_next  = '0;
                        if (fl1_reg != 16'd0)
                        begin
                            phase_next = pkbed_pkg::PH_KEY;
                            rem_next   = fl1_reg;
                        end
                        else if (fl2_reg != 16'd0)
                        begin
                            phase_next = pkbed_pkg::PH_VAL;
                            rem_next   = fl2_reg;
                        end
                        else
                        begin
                            phase_next = pkbed_pkg::PH_SHARED;
                        end
                        if (fl0_reg == 16'd0)
                        begin
                            do_emit               = 1'b1;
                            out_next.kind         = pkbed_pkg::KIND_HEADER;
                            out_next.out_byte     = 8'd0;
                            out_next.position     = 16'd0;
                            out_next.end_of_entry = chk_empty;
                            out_next.block_done   = chk_empty && chk_done;
                        end
                    end
                end
            end
            pkbed_pkg::ST_READ:
            begin
                ram_re = 1'b1;
            end
            pkbed_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    do_emit               = 1'b1;
                    out_next.kind         = pkbed_pkg::KIND_KEY;
                    out_next.out_byte     = ram_rdata;
                    out_next.position     = {{pkbed_pkg::KeyLenPad{1'b0}}, rd_idx_reg};
                    out_next.end_of_entry = replay_last && chk_empty;
                    out_next.block_done   = replay_last && chk_empty && chk_done;
                    rd_idx_next           = rd_idx_reg + pkbed_pkg::KeyLenW'(1);
                end
            end
            default:
            begin
            end
        endcase

        if (do_emit)
        begin
            m_valid_next          = 1'b1;
            out_next.shared_len   = fl0_reg;
            out_next.unshared_len = fl1_reg;
            out_next.value_len    = fl2_reg;
            out_next.error_code   = pkbed_pkg::ERR_NONE;
            out_next.last_of_run  = (state_reg != pkbed_pkg::ST_EMIT) || replay_last;
        end
        if (do_fail)
        begin
            err_next              = 1'b1;
            m_valid_next          = 1'b1;
            out_next.kind         = pkbed_pkg::KIND_ERROR;
            out_next.out_byte     = 8'd0;
            out_next.position     = 16'd0;
            out_next.shared_len   = 16'd0;
            out_next.unshared_len = 16'd0;
            out_next.value_len    = 16'd0;
            out_next.end_of_entry = 1'b0;
            out_next.block_done   = 1'b0;
            out_next.error_code   = fail_code;
            out_next.last_of_run  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pkbed_pkg::ST_IDLE;
            phase_reg   <= pkbed_pkg::PH_SHARED;
            rl_reg      <= 16'd0;
            bc_reg      <= 16'd0;
            acc_reg     <= 16'd0;
            ovf_reg     <= 1'b0;
            vb_reg      <= 3'd0;
            fl0_reg     <= 16'd0;
            fl1_reg     <= 16'd0;
            fl2_reg     <= 16'd0;
            rem_reg     <= 16'd0;
            key_len_reg <= '0;
            rd_idx_reg  <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            if (cfg_valid && cfg_ready)
            begin
                rl_reg <= cfg_data;
            end
            bc_reg      <= bc_next;
            acc_reg     <= acc_next;
            ovf_reg     <= ovf_next;
            vb_reg      <= vb_next;
            fl0_reg     <= fl0_next;
            fl1_reg     <= fl1_next;
            fl2_reg     <= fl2_next;
            rem_reg     <= rem_next;
            key_len_reg <= key_len_next;
            rd_idx_reg  <= rd_idx_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // replay never reads past the stored key
    `PKBED_ASSERT_IMP(a_replay_in_key, state_reg == pkbed_pkg::ST_READ,
        {{pkbed_pkg::KeyLenPad{1'b0}}, rd_idx_reg} < fl0_reg && rd_idx_reg < key_len_reg)
    // RAM data is only consumed the cycle after a read or while held
    `PKBED_ASSERT_NXT(a_emit_after_read, state_reg == pkbed_pkg::ST_READ,
        state_reg == pkbed_pkg::ST_EMIT)
    // an error result always leaves the decoder latched
    `PKBED_ASSERT_IMP(a_error_latched,
        m_valid_reg && out_reg.kind == pkbed_pkg::KIND_ERROR, err_reg)
    // stored key length stays within the key store
    `PKBED_ASSERT_IMP(a_key_len_max, 1'b1,
        key_len_reg <= pkbed_pkg::KeyLenW'(pkbed_pkg::KeyBytesMax))

endmodule

// ===== tb/prefix_key_block_entry_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_key_block_entry_decoder_tb
// Streams sorted-table entry regions into the decoder, byte by byte, and
// checks every result transfer against an in-bench predictor of key rebuild,
// prefix replay, length checks and corruption handling. Directed blocks hit
// the corner cases, then random well-formed, broken and noise blocks follow
// with random stalls on both streams.
// ----------------------------------------------------------------------------

class entry_decode_board;
    bit [7:0]             key_mem [pkbed_pkg::KeyBytesMax];
    int unsigned          key_len;
    int unsigned          byte_cnt;
    int unsigned          acc_bytes;
    int unsigned          remaining;
    int unsigned          flen [3];
    int unsigned          region;
    bit [31:0]            acc;
    pkbed_pkg::phase_t    phase;
    bit                   err_latched;
    pkbed_pkg::result_t   pending_results [$];
    int                   errors;

    function new();
        region = 0;
        errors = 0;
        clear_block();
    endfunction

    function void clear_block();
        key_len     = 0;
        byte_cnt    = 0;
        acc_bytes   = 0;
        remaining   = 0;
        flen        = '{0, 0, 0};
        acc         = '0;
        phase       = pkbed_pkg::PH_SHARED;
        err_latched = 1'b0;
    endfunction

    function pkbed_pkg::result_t make_result(pkbed_pkg::kind_t k, bit [7:0] b,
                                             int unsigned pos);
        pkbed_pkg::result_t r;
        r              = '0;
        r.kind         = k;
        r.out_byte     = b;
        r.position     = pos[15:0];
        r.shared_len   = flen[0][15:0];
        r.unshared_len = flen[1][15:0];
        r.value_len    = flen[2][15:0];
        r.error_code   = pkbed_pkg::ERR_NONE;
        return r;
    endfunction

    function void add_error(pkbed_pkg::err_code_t code);
        pkbed_pkg::result_t r;
        r             = '0;
        r.kind        = pkbed_pkg::KIND_ERROR;
        r.error_code  = code;
        r.last_of_run = 1'b1;
        err_latched   = 1'b1;
        pending_results.push_back(r);
    endfunction

    // returns 0 when the byte is ignored by the decoder
    function bit note_byte(bit [7:0] b, bit start);
        pkbed_pkg::result_t run [$];
        pkbed_pkg::result_t r;
        bit                 entry_end;
        int unsigned        left;
        int unsigned        need;
        int unsigned        shared;
        entry_end = 1'b0;
        if (start)
            clear_block();
        if (err_latched)
            return 1'b0;

        if (phase == pkbed_pkg::PH_SHARED || phase == pkbed_pkg::PH_UNSHARED ||
            phase == pkbed_pkg::PH_VALUE)
        begin
            if (phase == pkbed_pkg::PH_SHARED && acc_bytes == 0)
            begin
                if (byte_cnt >= region)
                    return 1'b0;
                if (region - byte_cnt < 3)
                begin
                    add_error(pkbed_pkg::ERR_REGION);
                    return 1'b1;
                end
            end
            else if (byte_cnt >= region)
            begin
                add_error(pkbed_pkg::ERR_REGION);
                return 1'b1;
            end
            byte_cnt++;
            acc |= 32'(b[6:0]) << (7 * acc_bytes);
            if (b[7])
            begin
                if (acc_bytes >= 4)
                    add_error(pkbed_pkg::ERR_VARINT);
                else
                    acc_bytes++;
                return 1'b1;
            end
            flen[int'(phase)] = (acc > 32'hFFFF) ? 32'hFFFF : acc;
            acc       = '0;
            acc_bytes = 0;
            if (phase != pkbed_pkg::PH_VALUE)
            begin
                phase = (phase == pkbed_pkg::PH_SHARED) ? pkbed_pkg::PH_UNSHARED
                                                        : pkbed_pkg::PH_VALUE;
                return 1'b1;
            end
            left   = (byte_cnt < region) ? region - byte_cnt : 0;
            need   = flen[1] + flen[2];
            shared = flen[0];
            if (need > left)
            begin
                add_error(pkbed_pkg::ERR_REGION);
                return 1'b1;
            end
            if (shared > key_len)
            begin
                add_error(pkbed_pkg::ERR_PREFIX);
                return 1'b1;
            end
            if (shared + flen[1] > pkbed_pkg::KeyBytesMax)
            begin
                add_error(pkbed_pkg::ERR_KEY_LONG);
                return 1'b1;
            end
            if (shared == 0)
                run.push_back(make_result(pkbed_pkg::KIND_HEADER, 8'h00, 0));
            else
                for (int i = 0; i < shared; i++)
                    run.push_back(make_result(pkbed_pkg::KIND_KEY, key_mem[i], i));
            key_len = shared;
            if (flen[1] != 0)
            begin
                phase     = pkbed_pkg::PH_KEY;
                remaining = flen[1];
            end
            else if (flen[2] != 0)
            begin
                phase     = pkbed_pkg::PH_VAL;
                remaining = flen[2];
            end
            else
                entry_end = 1'b1;
        end
        else if (phase == pkbed_pkg::PH_KEY)
        begin
            if (byte_cnt < 65535)
                byte_cnt++;
            run.push_back(make_result(pkbed_pkg::KIND_KEY, b, key_len));
            if (key_len < pkbed_pkg::KeyBytesMax)
            begin
                key_mem[key_len] = b;
                key_len++;
            end
            if (remaining != 0)
                remaining--;
            if (remaining == 0)
            begin
                if (flen[2] != 0)
                begin
                    phase     = pkbed_pkg::PH_VAL;
                    remaining = flen[2];
                end
                else
                    entry_end = 1'b1;
            end
        end
        else
        begin
            if (byte_cnt < 65535)
                byte_cnt++;
            run.push_back(make_result(pkbed_pkg::KIND_VALUE, b, flen[2] - remaining));
            if (remaining != 0)
                remaining--;
            if (remaining == 0)
                entry_end = 1'b1;
        end

        for (int i = 0; i < run.size(); i++)
        begin
            r = run[i];
            if (i == run.size() - 1)
            begin
                r.last_of_run  = 1'b1;
                r.end_of_entry = entry_end;
                r.block_done   = entry_end && (byte_cnt >= region);
            end
            pending_results.push_back(r);
        end
        if (entry_end)
            phase = pkbed_pkg::PH_SHARED;
        return 1'b1;
    endfunction

    task report(string msg);
        $display("%0t mismatch: %s", $time, msg);
        errors++;
    endtask

    task cmp_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task check_result(pkbed_pkg::result_t got);
        pkbed_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            report("result transfer with nothing expected");
            return;
        end
        want = pending_results.pop_front();
        cmp_field("kind", got.kind, want.kind);
        cmp_field("out_byte", got.out_byte, want.out_byte);
        cmp_field("position", got.position, want.position);
        cmp_field("shared_len", got.shared_len, want.shared_len);
        cmp_field("unshared_len", got.unshared_len, want.unshared_len);
        cmp_field("value_len", got.value_len, want.value_len);
        cmp_field("end_of_entry", got.end_of_entry, want.end_of_entry);
        cmp_field("block_done", got.block_done, want.block_done);
        cmp_field("error_code", got.error_code, want.error_code);
        cmp_field("last_of_run", got.last_of_run, want.last_of_run);
    endtask
endclass

module prefix_key_block_entry_decoder_tb;

    localparam int       CycleLimit  = 2_000_000;
    localparam int       SettleCycles = 24;
    localparam int       RandomItems = 450;
    localparam int       CalmTail    = 80;
    localparam bit [8:0] START       = 9'h100;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
    logic        s_axis_tuser  = 1'b0;  // [0] block_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;          // out_byte, position, shared_len, unshared_len,
                                        // value_len, end_of_entry, block_done, error_code
    logic [1:0]  m_axis_tuser;          // [1:0] kind
    logic        m_axis_tlast;

    entry_decode_board  board;
    pkbed_pkg::result_t seen_result;
    bit                 idle_on     = 1'b1;
    int unsigned        stall_left  = 0;
    int unsigned        taken_items = 0;
    int unsigned        cycles      = 0;

    prefix_key_block_entry_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CycleLimit)
        begin
            $display("prefix_key_block_entry_decoder_tb: FAIL");
            $finish;
        end
    end

    // result side: check transfers, stall tready in bursts
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_result              = '0;
            seen_result.out_byte     = m_axis_tdata[7:0];
            seen_result.position     = m_axis_tdata[23:8];
            seen_result.shared_len   = m_axis_tdata[39:24];
            seen_result.unshared_len = m_axis_tdata[55:40];
            seen_result.value_len    = m_axis_tdata[71:56];
            seen_result.end_of_entry = m_axis_tdata[72];
            seen_result.block_done   = m_axis_tdata[73];
            seen_result.error_code   = pkbed_pkg::err_code_t'(m_axis_tdata[76:74]);
            seen_result.kind         = pkbed_pkg::kind_t'(m_axis_tuser);
            seen_result.last_of_run  = m_axis_tlast;
            board.check_result(seen_result);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task write_region(int unsigned v);
        cfg_valid <= 1'b1;
        cfg_data  <= v[15:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        board.region = v[15:0];
        cfg_valid <= 1'b0;
    endtask

    task send_byte(bit [8:0] w);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w[7:0];
        s_axis_tuser  <= w[8];
        do
            @(posedge clk);
        while (!s_axis_tready);
        void'(board.note_byte(w[7:0], w[8]));
        taken_items++;
    endtask

    // idle point: all results in, then let no-result bytes settle
    task drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_results.size() != 0);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic run_block(ref bit [8:0] q[$], input int unsigned region);
        write_region(region);
        foreach (q[i])
            send_byte(q[i]);
        drain();
    endtask

    task automatic put_varint(ref bit [8:0] q[$], input int unsigned v, input int unsigned pad);
        int unsigned groups;
        int unsigned n;
        groups = 1;
        while (groups < 5 && (v >> (7 * groups)) != 0)
            groups++;
        n = (groups + pad > 5) ? 5 : groups + pad;
        for (int k = 0; k < n; k++)
            q.push_back({1'b0, (k < n - 1) ? 1'b1 : 1'b0, 7'((v >> (7 * k)) & 127)});
    endtask

    task automatic build_block(ref bit [8:0] q[$], output int unsigned region);
        int unsigned mode;
        int unsigned klen;
        int unsigned shared;
        int unsigned unsh;
        int unsigned vlen;
        int unsigned n_ent;
        int unsigned flaw;
        q.delete();
        klen = 0;
        mode = $urandom_range(0, 9);
        if (mode == 9)
        begin
            repeat ($urandom_range(1, 20))
                q.push_back({($urandom_range(0, 5) == 0) ? 1'b1 : 1'b0, 8'($urandom)});
            q[0] = q[0] | START;
            case ($urandom_range(0, 2))
                0:       region = 0;
                1:       region = 65535;
                default: region = $urandom_range(0, 40);
            endcase
            return;
        end
        n_ent = $urandom_range(1, 6);
        for (int e = 0; e < n_ent; e++)
        begin
            shared = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, klen);
            if ($urandom_range(0, 7) == 0)
                unsh = $urandom_range(0, 64 - shared);
            else
                unsh = $urandom_range(0, (64 - shared < 6) ? 64 - shared : 6);
            vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 4);
            flaw = (mode == 7) ? $urandom_range(0, 4) : 4;
            case (flaw)
                0: shared = klen + $urandom_range(1, 3);
                1: unsh = 65 - shared + $urandom_range(0, 2);
                2: vlen = $urandom | 32'h0001_0000;
                default: ;
            endcase
            if (flaw == 3)
            begin
                // five-byte length with continuation still set
                repeat (4) q.push_back(9'h0FF);
                q.push_back({1'b0, 1'b1, 7'($urandom)});
            end
            else
            begin
                put_varint(q, shared, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0);
                put_varint(q, unsh, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0);
                put_varint(q, vlen, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0);
            end
            if (flaw != 4)
            begin
                repeat ($urandom_range(0, 3)) q.push_back({1'b0, 8'($urandom)});
                break;
            end
            repeat (unsh) q.push_back({1'b0, 8'($urandom)});
            repeat (vlen) q.push_back({1'b0, 8'($urandom)});
            klen = shared + unsh;
        end
        q[0] = q[0] | START;
        region = q.size();
        if (mode == 8)
        begin
            region += $urandom_range(0, 2);
            repeat ($urandom_range(1, 4)) q.push_back({1'b0, 8'($urandom)});
        end
        else if (mode == 6)
            region = $urandom_range(0, q.size() - 1);
        else if (mode == 7 && $urandom_range(0, 1) == 1)
            q[$urandom_range(1, q.size() - 1)] = {1'b0, 8'($urandom)};
    endtask

    initial
    begin
        bit [8:0]    blk [$];
        int unsigned region;
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // two entries, second reuses the whole first key, ends the region
        blk = '{START | 9'h000, 9'h002, 9'h001, 9'h000, 9'h0FF, 9'h080,
                9'h002, 9'h000, 9'h000};
        run_block(blk, 9);
        // empty region: byte ignored
        blk = '{START | 9'h055};
        run_block(blk, 0);
        // overlong varint
        blk = '{START | 9'h080, 9'h080, 9'h080, 9'h080, 9'h080};
        run_block(blk, 65535);
        // saturated shared length, prefix too long, then a byte after the error
        blk = '{START | 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h00F, 9'h000, 9'h000, 9'h001};
        run_block(blk, 65535);
        // key longer than the key store
        blk = '{START | 9'h000, 9'h041, 9'h000};
        run_block(blk, 70);
        // fewer than three bytes left at entry start
        blk = '{START | 9'h000};
        run_block(blk, 2);

        taken_items = 0;
        while (taken_items < RandomItems)
        begin
            idle_on = (taken_items < RandomItems - CalmTail) && ($urandom_range(0, 4) != 0);
            build_block(blk, region);
            run_block(blk, region);
        end

        if (board.errors == 0)
            $display("prefix_key_block_entry_decoder_tb: PASS");
        else
            $display("prefix_key_block_entry_decoder_tb: FAIL");
        $finish;
    end

endmodule

// ===== prefix_key_block_entry_decoder.f =====
+incdir+rtl
rtl/pkbed_pkg.sv
rtl/pkbed_ram.sv
rtl/prefix_key_block_entry_decoder.sv
tb/prefix_key_block_entry_decoder_tb.sv
